// File: hdl/tmcs_pkg.sv
package tmcs_pkg;

   localparam int MAX_DIM_LOG2_DEFAULT = 14;
   localparam int MAX_LAYERS_DEFAULT = 2048;

   localparam int KIND_W = 4;
   localparam int DIM_W = 15;
   localparam int SURF_W = 12;
   localparam int REQ_W = 5;
   localparam int MIPS_W = 4;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W = 45;
   localparam int COUNT_W = 15;

   localparam int BLK_W = DIM_W - 1;
   localparam int ROW_W = DIM_W + 4;
   localparam int PITCH_W = ROW_W + DIM_W;
   localparam int ACC_W = 48;
   localparam int CNT_ACC_W = 16;

   localparam logic [KIND_W-1:0] KIND_UNDEFINED = 4'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL_FIRST = 4'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL_LAST = 4'd5;
   localparam logic [KIND_W-1:0] KIND_BLOCK8 = 4'd6;
   localparam logic [KIND_W-1:0] KIND_BLOCK16 = 4'd7;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK = 2'd0,
      STATUS_BAD_DESC = 2'd1,
      STATUS_TOO_MANY_MIPS = 2'd2
   } status_type;

   typedef struct packed {
      logic valid;
      status_type status;
      logic [MIPS_W-1:0] mips;
      logic [MIPS_W-1:0] remain;
      logic [KIND_W-1:0] kind;
      logic is_volume;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [SURF_W-1:0] surfaces;
      logic [PITCH_W-1:0] pitch;
      logic [SURF_W-1:0] pitch_surfaces;
      logic [ACC_W-1:0] total;
      logic [CNT_ACC_W-1:0] count;
   } level_bus_type;

endpackage

// File: hdl/tmcs_front.sv
module tmcs_front #(
   parameter int MAX_DIM_LOG2 = tmcs_pkg::MAX_DIM_LOG2_DEFAULT,
   parameter int MAX_LAYERS = tmcs_pkg::MAX_LAYERS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [tmcs_pkg::KIND_W-1:0] format_kind,
   input  logic is_volume,
   input  logic [tmcs_pkg::DIM_W-1:0] base_width,
   input  logic [tmcs_pkg::DIM_W-1:0] base_height,
   input  logic [tmcs_pkg::SURF_W-1:0] layers_or_depth,
   input  logic [tmcs_pkg::REQ_W-1:0] mip_request,
   output tmcs_pkg::level_bus_type bus_out
);

   localparam int LIM_W = 17;
   localparam logic [LIM_W-1:0] DIM_LIMIT = LIM_W'(1) << MAX_DIM_LOG2;
   localparam logic [LIM_W-1:0] LAYER_LIMIT = LIM_W'(MAX_LAYERS);

   tmcs_pkg::level_bus_type bus_ff;
   tmcs_pkg::level_bus_type bus_in;

   function automatic logic [tmcs_pkg::MIPS_W-1:0] chain_len(
      input logic [tmcs_pkg::DIM_W-1:0] v
   );
      logic [tmcs_pkg::MIPS_W-1:0] n;
      n = '0;
      for (int i = 0; i < tmcs_pkg::DIM_W; i++) begin
         if (v[i]) begin
            n = tmcs_pkg::MIPS_W'(i + 1);
         end
      end
      return n;
   endfunction

   logic [tmcs_pkg::MIPS_W-1:0] chain;
   logic size_bad;

   always_comb begin
      chain = chain_len(base_width | base_height);
      size_bad = (base_width == '0) || (base_height == '0) || (layers_or_depth == '0) ||
                 (LIM_W'(base_width) > DIM_LIMIT) || (LIM_W'(base_height) > DIM_LIMIT) ||
                 (LIM_W'(layers_or_depth) > LAYER_LIMIT);

      bus_in = '0;
      bus_in.valid = accept;
      bus_in.kind = format_kind;
      bus_in.is_volume = is_volume;
      bus_in.width = base_width;
      bus_in.height = base_height;
      bus_in.surfaces = layers_or_depth;

      priority if (format_kind == tmcs_pkg::KIND_UNDEFINED) begin
         bus_in.status = tmcs_pkg::STATUS_BAD_DESC;
      end else if (size_bad) begin
         bus_in.status = tmcs_pkg::STATUS_BAD_DESC;
      end else if (mip_request == '0) begin
         bus_in.status = tmcs_pkg::STATUS_OK;
         bus_in.mips = chain;
      end else if (mip_request == tmcs_pkg::REQ_W'(1)) begin
         bus_in.status = tmcs_pkg::STATUS_OK;
         bus_in.mips = tmcs_pkg::MIPS_W'(1);
      end else if (mip_request > tmcs_pkg::REQ_W'(chain)) begin
         bus_in.status = tmcs_pkg::STATUS_TOO_MANY_MIPS;
      end else begin
         bus_in.status = tmcs_pkg::STATUS_OK;
         bus_in.mips = mip_request[tmcs_pkg::MIPS_W-1:0];
      end
      bus_in.remain = bus_in.mips;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff <= bus_in;
      end
   end

   assign bus_out = bus_ff;

endmodule

// File: hdl/tmcs_cell.sv
module tmcs_cell (
   input  logic clock,
   input  logic reset,
   input  tmcs_pkg::level_bus_type bus_in_prev,
   output tmcs_pkg::level_bus_type bus_out
);

   tmcs_pkg::level_bus_type bus_ff;
   tmcs_pkg::level_bus_type bus_in;

   logic include_level;
   logic is_block;
   logic is_pixel;
   logic [tmcs_pkg::DIM_W:0] w_sum;
   logic [tmcs_pkg::DIM_W:0] h_sum;
   logic [tmcs_pkg::BLK_W-1:0] blk_w;
   logic [tmcs_pkg::BLK_W-1:0] blk_h;
   logic [2:0] row_shift;
   logic [tmcs_pkg::ROW_W-1:0] row_bytes;
   logic [tmcs_pkg::ROW_W-1:0] mul_a;
   logic [tmcs_pkg::DIM_W-1:0] mul_b;
   logic [tmcs_pkg::PITCH_W-1:0] product;
   logic [tmcs_pkg::PITCH_W-1:0] slice;

   always_comb begin
      include_level = bus_in_prev.remain != '0;
      is_block = (bus_in_prev.kind == tmcs_pkg::KIND_BLOCK8) ||
                 (bus_in_prev.kind == tmcs_pkg::KIND_BLOCK16);
      is_pixel = (bus_in_prev.kind >= tmcs_pkg::KIND_PIXEL_FIRST) &&
                 (bus_in_prev.kind <= tmcs_pkg::KIND_PIXEL_LAST);

      w_sum = {1'b0, bus_in_prev.width} + (tmcs_pkg::DIM_W + 1)'(3);
      h_sum = {1'b0, bus_in_prev.height} + (tmcs_pkg::DIM_W + 1)'(3);
      blk_w = w_sum[tmcs_pkg::DIM_W:2];
      blk_h = h_sum[tmcs_pkg::DIM_W:2];
      row_shift = 3'(bus_in_prev.kind - tmcs_pkg::KIND_PIXEL_FIRST);
      row_bytes = tmcs_pkg::ROW_W'(bus_in_prev.width) << row_shift;

      if (is_block) begin
         mul_a = tmcs_pkg::ROW_W'(blk_w);
         mul_b = tmcs_pkg::DIM_W'(blk_h);
      end else begin
         mul_a = is_pixel ? row_bytes : '0;
         mul_b = bus_in_prev.height;
      end
      product = tmcs_pkg::PITCH_W'(mul_a) * tmcs_pkg::PITCH_W'(mul_b);

      if (is_block) begin
         slice = (bus_in_prev.kind == tmcs_pkg::KIND_BLOCK16) ? (product << 4) : (product << 3);
      end else begin
         slice = product;
      end

      bus_in = bus_in_prev;
      bus_in.total = bus_in_prev.total +
                     tmcs_pkg::ACC_W'(bus_in_prev.pitch) *
                     tmcs_pkg::ACC_W'(bus_in_prev.pitch_surfaces);
      bus_in.pitch = include_level ? slice : '0;
      bus_in.pitch_surfaces = bus_in_prev.surfaces;
      bus_in.count = bus_in_prev.count +
                     (include_level ? tmcs_pkg::CNT_ACC_W'(bus_in_prev.surfaces) : '0);
      bus_in.remain = include_level ? bus_in_prev.remain - tmcs_pkg::MIPS_W'(1) : '0;
      bus_in.width = (bus_in_prev.width > tmcs_pkg::DIM_W'(1)) ?
                     (bus_in_prev.width >> 1) : bus_in_prev.width;
      bus_in.height = (bus_in_prev.height > tmcs_pkg::DIM_W'(1)) ?
                      (bus_in_prev.height >> 1) : bus_in_prev.height;
      bus_in.surfaces = (bus_in_prev.is_volume && bus_in_prev.surfaces > tmcs_pkg::SURF_W'(1)) ?
                        (bus_in_prev.surfaces >> 1) : bus_in_prev.surfaces;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff <= bus_in;
      end
   end

   assign bus_out = bus_ff;

endmodule

// File: hdl/tmcs_tail.sv
module tmcs_tail (
   input  logic clock,
   input  logic reset,
   input  tmcs_pkg::level_bus_type bus_in_last,
   output logic rsp_valid,
   output logic [tmcs_pkg::STATUS_W-1:0] rsp_status,
   output logic [tmcs_pkg::MIPS_W-1:0] rsp_mip_count,
   output logic [tmcs_pkg::TOTAL_W-1:0] rsp_total_bytes,
   output logic [tmcs_pkg::COUNT_W-1:0] rsp_image_count
);

   logic valid_ff;
   logic [tmcs_pkg::STATUS_W-1:0] status_ff;
   logic [tmcs_pkg::MIPS_W-1:0] mips_ff;
   logic [tmcs_pkg::TOTAL_W-1:0] total_ff;
   logic [tmcs_pkg::COUNT_W-1:0] count_ff;
   logic [tmcs_pkg::TOTAL_W-1:0] total_in;
   logic [tmcs_pkg::COUNT_W-1:0] count_in;

   always_comb begin
      total_in = (|bus_in_last.total[tmcs_pkg::ACC_W-1:tmcs_pkg::TOTAL_W]) ?
                 '1 : bus_in_last.total[tmcs_pkg::TOTAL_W-1:0];
      count_in = (|bus_in_last.count[tmcs_pkg::CNT_ACC_W-1:tmcs_pkg::COUNT_W]) ?
                 '1 : bus_in_last.count[tmcs_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= bus_in_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= bus_in_last.status;
      mips_ff <= bus_in_last.mips;
      total_ff <= total_in;
      count_ff <= count_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_mip_count = mips_ff;
   assign rsp_total_bytes = total_ff;
   assign rsp_image_count = count_ff;

endmodule

// File: hdl/texture_mip_chain_size.sv
// Computes the mip level count, total byte size and surface count of one texture
// description per transaction; a request is taken when start is high and busy is low,
// and the result appears for a single cycle on the rsp_ ports with rsp_valid high and
// cannot be stalled, so the receiver must capture it in that cycle. The description is
// checked in a front stage and then passes down a row of MAX_DIM_LOG2+2 cells (16 by
// default, and never more than 16, since the size ports allow no more than 15 levels),
// each cell adding the pitch of one mip level and registering the result; the strobe
// comes from a tail register after the last cell, and busy falls with it, so a new
// description is taken only once the last one has left the row. Totals saturate at
// the width of their ports.
module texture_mip_chain_size #(
   parameter int MAX_DIM_LOG2 = tmcs_pkg::MAX_DIM_LOG2_DEFAULT,
   parameter int MAX_LAYERS = tmcs_pkg::MAX_LAYERS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [tmcs_pkg::KIND_W-1:0] req_format_kind,
   input  logic req_is_volume,
   input  logic [tmcs_pkg::DIM_W-1:0] req_base_width,
   input  logic [tmcs_pkg::DIM_W-1:0] req_base_height,
   input  logic [tmcs_pkg::SURF_W-1:0] req_layers_or_depth,
   input  logic [tmcs_pkg::REQ_W-1:0] req_mip_request,
   output logic rsp_valid,
   output logic [tmcs_pkg::STATUS_W-1:0] rsp_status,
   output logic [tmcs_pkg::MIPS_W-1:0] rsp_mip_count,
   output logic [tmcs_pkg::TOTAL_W-1:0] rsp_total_bytes,
   output logic [tmcs_pkg::COUNT_W-1:0] rsp_image_count
);

   localparam int LEVELS =
      ((MAX_DIM_LOG2 < tmcs_pkg::DIM_W - 1) ? MAX_DIM_LOG2 : tmcs_pkg::DIM_W - 1) + 1;
   localparam int CELLS = LEVELS + 1;

   tmcs_pkg::level_bus_type row_bus [0:CELLS];

   logic accept;
   logic busy_ff;
   logic busy_in;

   assign accept = start && !busy_ff;

   tmcs_front #(
      .MAX_DIM_LOG2(MAX_DIM_LOG2),
      .MAX_LAYERS(MAX_LAYERS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .format_kind(req_format_kind),
      .is_volume(req_is_volume),
      .base_width(req_base_width),
      .base_height(req_base_height),
      .layers_or_depth(req_layers_or_depth),
      .mip_request(req_mip_request),
      .bus_out(row_bus[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tmcs_cell u_cell (
         .clock(clock),
         .reset(reset),
         .bus_in_prev(row_bus[i]),
         .bus_out(row_bus[i+1])
      );
   end

   tmcs_tail u_tail (
      .clock(clock),
      .reset(reset),
      .bus_in_last(row_bus[CELLS]),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_mip_count(rsp_mip_count),
      .rsp_total_bytes(rsp_total_bytes),
      .rsp_image_count(rsp_image_count)
   );

   always_comb begin
      priority if (accept) begin
         busy_in = 1'b1;
      end else if (row_bus[CELLS].valid) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

`ifndef SYNTH
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe without a transaction in flight");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_error_clears_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != tmcs_pkg::STATUS_OK) |->
      (rsp_mip_count == '0 && rsp_total_bytes == '0 && rsp_image_count == '0))
      else $error("error result carries nonzero fields");
`endif

endmodule

// File: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_DIM = 32'd1 << tmcs_pkg::MAX_DIM_LOG2_DEFAULT;
   localparam int unsigned MAX_SURFACES = tmcs_pkg::MAX_LAYERS_DEFAULT;
   localparam longint unsigned TOTAL_MAX = (64'd1 << tmcs_pkg::TOTAL_W) - 64'd1;
   localparam longint unsigned IMAGES_MAX = (64'd1 << tmcs_pkg::COUNT_W) - 64'd1;
   localparam int LATENCY = tmcs_pkg::MAX_DIM_LOG2_DEFAULT + 4;
   localparam int STALL_LIMIT = 400;
   localparam int RANDOM_PER_PHASE = 317;

   localparam logic [tmcs_pkg::KIND_W-1:0] KIND_PIXEL16 = 4'd2;
   localparam logic [tmcs_pkg::KIND_W-1:0] KIND_PIXEL32 = 4'd3;
   localparam logic [tmcs_pkg::KIND_W-1:0] KIND_PIXEL64 = 4'd4;
   localparam logic [tmcs_pkg::KIND_W-1:0] KIND_UNKNOWN = 4'd8;
   localparam logic [tmcs_pkg::KIND_W-1:0] KIND_RESERVED_LAST = 4'd15;

   typedef struct packed {
      logic [tmcs_pkg::STATUS_W-1:0] status;
      logic [tmcs_pkg::MIPS_W-1:0] mips;
      logic [tmcs_pkg::TOTAL_W-1:0] total;
      logic [tmcs_pkg::COUNT_W-1:0] images;
   } footprint_type;

   typedef struct packed {
      logic [tmcs_pkg::KIND_W-1:0] kind;
      logic vol;
      logic [tmcs_pkg::DIM_W-1:0] width;
      logic [tmcs_pkg::DIM_W-1:0] height;
      logic [tmcs_pkg::SURF_W-1:0] layers;
      logic [tmcs_pkg::REQ_W-1:0] req;
      logic typed;
      footprint_type result;
   } desc_type;

   localparam footprint_type BAD_DESC = '{tmcs_pkg::STATUS_BAD_DESC, '0, '0, '0};
   localparam footprint_type TOO_MANY = '{tmcs_pkg::STATUS_TOO_MANY_MIPS, '0, '0, '0};
   localparam footprint_type NONE = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   desc_type drive_desc = '0;
   logic busy;
   logic rsp_valid;
   logic [tmcs_pkg::STATUS_W-1:0] rsp_status;
   logic [tmcs_pkg::MIPS_W-1:0] rsp_mip_count;
   logic [tmcs_pkg::TOTAL_W-1:0] rsp_total_bytes;
   logic [tmcs_pkg::COUNT_W-1:0] rsp_image_count;

   footprint_type pending_footprints[$];
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;

   desc_type directed_rows [24] = '{
      '{tmcs_pkg::KIND_UNDEFINED, 1'b0, 15'd16, 15'd16, 12'd1, 5'd0, 1'b1, BAD_DESC},
      '{tmcs_pkg::KIND_BLOCK8, 1'b0, 15'd0, 15'd16, 12'd1, 5'd0, 1'b1, BAD_DESC},
      '{tmcs_pkg::KIND_PIXEL_FIRST, 1'b0, 15'd16, 15'd0, 12'd1, 5'd0, 1'b1, BAD_DESC},
      '{KIND_PIXEL32, 1'b1, 15'd16, 15'd16, 12'd0, 5'd0, 1'b1, BAD_DESC},
      '{tmcs_pkg::KIND_PIXEL_LAST, 1'b0, 15'd16385, 15'd1, 12'd1, 5'd0, 1'b1, BAD_DESC},
      '{tmcs_pkg::KIND_BLOCK16, 1'b0, 15'd1, 15'd16385, 12'd1, 5'd0, 1'b1, BAD_DESC},
      '{KIND_PIXEL16, 1'b0, 15'd8, 15'd8, 12'd2049, 5'd0, 1'b1, BAD_DESC},
      '{KIND_PIXEL64, 1'b1, 15'd32767, 15'd32767, 12'd4095, 5'd31, 1'b1, BAD_DESC},
      '{tmcs_pkg::KIND_UNDEFINED, 1'b1, 15'd0, 15'd0, 12'd0, 5'd31, 1'b1, BAD_DESC},
      '{tmcs_pkg::KIND_PIXEL_FIRST, 1'b0, 15'd1, 15'd1, 12'd1, 5'd2, 1'b1, TOO_MANY},
      '{tmcs_pkg::KIND_BLOCK8, 1'b0, 15'd16384, 15'd16384, 12'd2048, 5'd31, 1'b1,
        TOO_MANY},
      '{KIND_PIXEL64, 1'b0, 15'd255, 15'd17, 12'd1, 5'd16, 1'b1, TOO_MANY},
      '{tmcs_pkg::KIND_PIXEL_FIRST, 1'b0, 15'd1, 15'd1, 12'd1, 5'd0, 1'b1,
        '{tmcs_pkg::STATUS_OK, 4'd1, 45'd1, 15'd1}},
      '{tmcs_pkg::KIND_PIXEL_FIRST, 1'b0, 15'd16384, 15'd16384, 12'd2048, 5'd1, 1'b1,
        '{tmcs_pkg::STATUS_OK, 4'd1, 45'd549755813888, 15'd2048}},
      '{tmcs_pkg::KIND_PIXEL_LAST, 1'b0, 15'd16384, 15'd16384, 12'd2048, 5'd0, 1'b0, NONE},
      '{tmcs_pkg::KIND_PIXEL_LAST, 1'b1, 15'd16384, 15'd16384, 12'd2048, 5'd0, 1'b0, NONE},
      '{KIND_UNKNOWN, 1'b0, 15'd100, 15'd37, 12'd5, 5'd0, 1'b0, NONE},
      '{KIND_RESERVED_LAST, 1'b1, 15'd7, 15'd3, 12'd9, 5'd0, 1'b0, NONE},
      '{tmcs_pkg::KIND_BLOCK8, 1'b0, 15'd1, 15'd1, 12'd3, 5'd0, 1'b0, NONE},
      '{tmcs_pkg::KIND_BLOCK16, 1'b1, 15'd13, 15'd6, 12'd11, 5'd3, 1'b0, NONE},
      '{KIND_PIXEL16, 1'b0, 15'd16384, 15'd1, 12'd1, 5'd15, 1'b0, NONE},
      '{KIND_PIXEL32, 1'b1, 15'd3, 15'd1000, 12'd2048, 5'd10, 1'b0, NONE},
      '{tmcs_pkg::KIND_PIXEL_LAST, 1'b1, 15'd1, 15'd16384, 12'd1, 5'd0, 1'b0, NONE},
      '{tmcs_pkg::KIND_BLOCK16, 1'b0, 15'd16384, 15'd16384, 12'd1, 5'd14, 1'b0, NONE}
   };

   texture_mip_chain_size dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_format_kind(drive_desc.kind),
      .req_is_volume(drive_desc.vol),
      .req_base_width(drive_desc.width),
      .req_base_height(drive_desc.height),
      .req_layers_or_depth(drive_desc.layers),
      .req_mip_request(drive_desc.req),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_mip_count(rsp_mip_count),
      .rsp_total_bytes(rsp_total_bytes),
      .rsp_image_count(rsp_image_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned chain_levels(longint unsigned w, longint unsigned h);
      longint unsigned n;
      n = 64'd1;
      while (w > 1 || h > 1) begin
         if (w > 1) w = w >> 1;
         if (h > 1) h = h >> 1;
         n++;
      end
      return n;
   endfunction

   function automatic footprint_type texture_footprint(desc_type d);
      footprint_type f;
      longint unsigned levels, lw, lh, ld, lvl, pitch, surfaces, total, images, bpp;
      f = '0;
      levels = 64'd0;
      if (d.kind == tmcs_pkg::KIND_UNDEFINED) begin
         f.status = tmcs_pkg::STATUS_BAD_DESC;
      end else if (d.width == 0 || d.height == 0 || d.layers == 0 || d.width > MAX_DIM ||
                   d.height > MAX_DIM || d.layers > MAX_SURFACES) begin
         f.status = tmcs_pkg::STATUS_BAD_DESC;
      end else begin
         levels = chain_levels(64'(d.width), 64'(d.height));
         if (d.req == 1) levels = 64'd1;
         else if (d.req > levels) f.status = tmcs_pkg::STATUS_TOO_MANY_MIPS;
         else if (d.req != 0) levels = 64'(d.req);
      end
      if (f.status == tmcs_pkg::STATUS_OK) begin
         lw = 64'(d.width);
         lh = 64'(d.height);
         ld = 64'(d.layers);
         total = 64'd0;
         images = 64'd0;
         for (lvl = 0; lvl < levels; lvl++) begin
            if (d.kind == tmcs_pkg::KIND_BLOCK8 || d.kind == tmcs_pkg::KIND_BLOCK16) begin
               pitch = ((lw + 3) / 4) * ((lh + 3) / 4) *
                       ((d.kind == tmcs_pkg::KIND_BLOCK8) ? 64'd8 : 64'd16);
            end else begin
               bpp = (d.kind >= tmcs_pkg::KIND_PIXEL_FIRST &&
                      d.kind <= tmcs_pkg::KIND_PIXEL_LAST) ? (64'd4 << d.kind) : 64'd0;
               pitch = ((lw * bpp + 7) / 8) * lh;
            end
            surfaces = d.vol ? ld : 64'(d.layers);
            total += pitch * surfaces;
            images += surfaces;
            if (lw > 1) lw = lw >> 1;
            if (lh > 1) lh = lh >> 1;
            if (d.vol && ld > 1) ld = ld >> 1;
         end
         f.mips = tmcs_pkg::MIPS_W'(levels);
         f.total = tmcs_pkg::TOTAL_W'((total > TOTAL_MAX) ? TOTAL_MAX : total);
         f.images = tmcs_pkg::COUNT_W'((images > IMAGES_MAX) ? IMAGES_MAX : images);
      end
      return f;
   endfunction

   task automatic issue_desc(desc_type d, int unsigned idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
      start <= 1'b1;
      drive_desc <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pending_footprints.push_back(drive_desc.typed ? drive_desc.result :
                                      texture_footprint(drive_desc));
      end
   end

   always @(posedge clock) begin
      footprint_type want;
      if (!reset && rsp_valid) begin
         if (pending_footprints.size() == 0) begin
            $display("%0t: unexpected transaction, status %0d mips %0d total %0d images %0d",
                     $time, rsp_status, rsp_mip_count, rsp_total_bytes, rsp_image_count);
            mismatch_count++;
         end else begin
            want = pending_footprints.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_mip_count !== want.mips) begin
               $display("%0t: mip_count expected %0d actual %0d", $time, want.mips,
                        rsp_mip_count);
               mismatch_count++;
            end
            if (rsp_total_bytes !== want.total) begin
               $display("%0t: total_bytes expected %0d actual %0d", $time, want.total,
                        rsp_total_bytes);
               mismatch_count++;
            end
            if (rsp_image_count !== want.images) begin
               $display("%0t: image_count expected %0d actual %0d", $time, want.images,
                        rsp_image_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      desc_type d;
      int unsigned phase, n, pick, idle_pct;
      longint unsigned levels;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) issue_desc(directed_rows[i], 0);
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 34 : (phase == 1) ? 63 : 0;
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            d = '0;
            pick = $urandom_range(99);
            if (pick < 4) begin
               d.kind = tmcs_pkg::KIND_UNDEFINED;
            end else if (pick < 10) begin
               d.kind = tmcs_pkg::KIND_W'($urandom_range(KIND_UNKNOWN, KIND_RESERVED_LAST));
            end else begin
               d.kind = tmcs_pkg::KIND_W'($urandom_range(tmcs_pkg::KIND_PIXEL_FIRST,
                                                         tmcs_pkg::KIND_BLOCK16));
            end
            d.vol = 1'($urandom_range(1));
            d.width = tmcs_pkg::DIM_W'($urandom_range(1,
                         MAX_DIM >> $urandom_range(0, tmcs_pkg::MAX_DIM_LOG2_DEFAULT)));
            d.height = tmcs_pkg::DIM_W'($urandom_range(1,
                          MAX_DIM >> $urandom_range(0, tmcs_pkg::MAX_DIM_LOG2_DEFAULT)));
            if ($urandom_range(99) < 3) d.width = tmcs_pkg::DIM_W'(MAX_DIM);
            if ($urandom_range(99) < 3) d.height = tmcs_pkg::DIM_W'(MAX_DIM);
            if ($urandom_range(99) < 4) begin
               d.width = $urandom_range(1) ? '0 :
                         tmcs_pkg::DIM_W'($urandom_range(16385, 32767));
            end
            if ($urandom_range(99) < 4) begin
               d.height = $urandom_range(1) ? '0 :
                          tmcs_pkg::DIM_W'($urandom_range(16385, 32767));
            end
            d.layers = ($urandom_range(3) == 0) ?
                       tmcs_pkg::SURF_W'($urandom_range(1, MAX_SURFACES)) :
                       tmcs_pkg::SURF_W'($urandom_range(1, 16));
            if ($urandom_range(99) < 4) begin
               d.layers = $urandom_range(1) ? '0 :
                          tmcs_pkg::SURF_W'($urandom_range(2049, 4095));
            end
            levels = chain_levels(64'(d.width), 64'(d.height));
            pick = $urandom_range(99);
            if (pick < 40) d.req = '0;
            else if (pick < 85) d.req = tmcs_pkg::REQ_W'($urandom_range(1, 32'(levels)));
            else d.req = tmcs_pkg::REQ_W'($urandom_range(0, 31));
            issue_desc(d, idle_pct);
         end
      end
      start <= 1'b0;
      while (pending_footprints.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
